// ===== rtl/fpf_pkg.sv =====
package fpf_pkg;

  localparam int RULE_SLOTS = 16;
  localparam int SLOT_W = $clog2(RULE_SLOTS);

  // Item kinds on the input tuser
  localparam logic [1:0] OP_FRAME_BYTE = 2'd0;
  localparam logic [1:0] OP_WRITE_RULE = 2'd1;
  localparam logic [1:0] OP_READ_COUNT = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Frame classes
  localparam logic [1:0] CLS_NOT_IPV4 = 2'd0;
  localparam logic [1:0] CLS_MALFORMED = 2'd1;
  localparam logic [1:0] CLS_RULES = 2'd2;

  // Counter indexes
  localparam logic [1:0] CNT_PROCESSED = 2'd0;
  localparam logic [1:0] CNT_INVALID = 2'd1;
  localparam logic [1:0] CNT_PASSED = 2'd2;
  localparam logic [1:0] CNT_DROPPED = 2'd3;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic        drop;
  } rule_t;

endpackage

// ===== rtl/five_tuple_packet_filter.sv =====
// channel | dir | tuser       | tlast      | tdata
// s_*     | in  | opcode      | frame_last | frame byte, rule write fields, counter_select
// m_*     | out | result_kind | -          | verdict fields, counter_value
//
// A last frame byte of a well-formed IPv4 frame starts a rule scan: one
// slot read from the rule RAM per cycle, each slot compared against the
// frame once its registered RAM output arrives.
// Other results appear the cycle after the item is accepted.
// Reset clears the rule enable bits, the byte position and all counters.
// Input is held off while a scan runs or while a result waits and cannot leave.
module five_tuple_packet_filter
  import fpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [7:0] frame_byte, [11:8] rule_slot, [43:12] rule_src_ip, [75:44] rule_dst_ip,
  // [91:76] rule source port, [107:92] rule_dst_port, [115:108] rule_protocol,
  // [116] rule_enabled, [117] rule_drop, [119:118] counter_select
  input  logic [119:0] s_tdata,
  input  logic         s_tlast,
  input  logic [1:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] drop_frame, [2:1] frame_class, [3] rule_hit, [7:4] hit_slot,
  // [71:8] counter_value
  output logic [71:0]  m_tdata,
  output logic         m_tuser    // result_kind
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic acc;
  logic [10:0] pos;
  logic [11:0] len;
  logic [7:0] byte_in;

  // Header fields picked off as bytes stream past
  logic [15:0] ethertype;
  logic [3:0]  ihl;
  logic [7:0]  proto;
  logic [31:0] sip, dip;
  logic [15:0] sport, dport;

  logic [63:0] cnt [4];

  logic [SLOT_W:0]   sc;
  logic              qv;
  logic [SLOT_W-1:0] qslot;
  rule_t             rq;
  logic              ren_q;
  rule_t             wrule;

  assign acc = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign byte_in = s_tdata[7:0];
  assign len = {1'b0, pos} + 12'd1;

  assign wrule.src_ip = s_tdata[43:12];
  assign wrule.dst_ip = s_tdata[75:44];
  assign wrule.source_port = s_tdata[91:76];
  assign wrule.dst_port = s_tdata[107:92];
  assign wrule.protocol = s_tdata[115:108];
  assign wrule.drop = s_tdata[117];

  fpf_rule_ram u_rules (
    .clk     (clk),
    .rst     (rst),
    .we      (acc && s_tuser == OP_WRITE_RULE),
    .waddr   (s_tdata[8 +: SLOT_W]),
    .wdata   (wrule),
    .wen_bit (s_tdata[116]),
    .raddr   (sc[SLOT_W-1:0]),
    .rdata   (rq),
    .ren_bit (ren_q)
  );

  // Transport header offset; at byte 14 the IHL is the byte itself
  logic [11:0] th_cur, th_reg;
  assign th_cur = (pos == 11'd14) ? 12'd14 + {6'd0, byte_in[3:0], 2'b00} : th_reg;
  assign th_reg = 12'd14 + {6'd0, ihl, 2'b00};

  always_ff @(posedge clk) begin
    if (acc && s_tuser == OP_FRAME_BYTE) begin
      if (pos == 11'd12) ethertype[15:8] <= byte_in;
      if (pos == 11'd13) ethertype[7:0] <= byte_in;
      if (pos == 11'd14) ihl <= byte_in[3:0];
      if (pos == 11'd23) proto <= byte_in;
      if (pos == 11'd26) sip[31:24] <= byte_in;
      if (pos == 11'd27) sip[23:16] <= byte_in;
      if (pos == 11'd28) sip[15:8] <= byte_in;
      if (pos == 11'd29) sip[7:0] <= byte_in;
      if (pos == 11'd30) dip[31:24] <= byte_in;
      if (pos == 11'd31) dip[23:16] <= byte_in;
      if (pos == 11'd32) dip[15:8] <= byte_in;
      if (pos == 11'd33) dip[7:0] <= byte_in;
      if (pos >= 11'd14) begin
        if ({1'b0, pos} == th_cur) sport[15:8] <= byte_in;
        if ({1'b0, pos} == th_cur + 12'd1) sport[7:0] <= byte_in;
        if ({1'b0, pos} == th_cur + 12'd2) dport[15:8] <= byte_in;
        if ({1'b0, pos} == th_cur + 12'd3) dport[7:0] <= byte_in;
      end
    end
  end

  // Classification of the frame at its last byte, using captured fields
  // plus the incoming byte where it is part of the needed header
  logic [15:0] et_f;
  logic [7:0]  pr_f;
  logic        is_tu;
  logic [11:0] need;
  always_comb begin
    et_f = (pos == 11'd13) ? {ethertype[15:8], byte_in} : ethertype;
    pr_f = proto;
    is_tu = (pr_f == PROTO_TCP) || (pr_f == PROTO_UDP);
    need = (pr_f == PROTO_TCP) ? 12'd20 : 12'd8;
  end

  logic [1:0] early_cls;
  logic       go_scan;
  always_comb begin
    go_scan = 1'b0;
    priority if (len < 12'd14) early_cls = CLS_MALFORMED;
    else if (et_f != 16'h0800) early_cls = CLS_NOT_IPV4;
    else if (len < 12'd34) early_cls = CLS_MALFORMED;
    else if (is_tu && (th_reg + need > len)) early_cls = CLS_MALFORMED;
    else begin
      early_cls = CLS_RULES;
      go_scan = 1'b1;
    end
  end

  // Ports are zero for protocols without a port header
  logic [15:0] sp_m, dp_m;
  logic        match;
  assign sp_m = is_tu ? sport : 16'd0;
  assign dp_m = is_tu ? dport : 16'd0;
  assign match = ren_q
    && (rq.src_ip == 32'd0 || rq.src_ip == sip)
    && (rq.dst_ip == 32'd0 || rq.dst_ip == dip)
    && (rq.source_port == 16'd0 || rq.source_port == sp_m)
    && (rq.dst_port == 16'd0 || rq.dst_port == dp_m)
    && (rq.protocol == 8'd0 || rq.protocol == pr_f);

  logic frame_done;
  assign frame_done = acc && s_tuser == OP_FRAME_BYTE && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos <= '0;
      m_tvalid <= 1'b0;
      sc <= '0;
      qv <= 1'b0;
      for (int i = 0; i < 4; i++) cnt[i] <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (acc && s_tuser == OP_FRAME_BYTE) begin
            if (s_tlast) begin
              pos <= '0;
            end else if (pos != 11'h7FF) begin
              pos <= pos + 11'd1;
            end
          end
          if (frame_done) begin
            if (go_scan) begin
              // Hold the verdict until the scan settles
              state <= ST_SCAN;
              sc <= '0;
              qv <= 1'b0;
            end else begin
              m_tvalid <= 1'b1;
              m_tuser <= 1'b0;
              m_tdata <= {64'd0, 4'd0, 1'b0, early_cls, 1'b0};
              cnt[CNT_PROCESSED] <= cnt[CNT_PROCESSED] + 64'd1;
              if (early_cls == CLS_MALFORMED) cnt[CNT_INVALID] <= cnt[CNT_INVALID] + 64'd1;
              else cnt[CNT_PASSED] <= cnt[CNT_PASSED] + 64'd1;
            end
          end else if (acc && s_tuser == OP_READ_COUNT) begin
            m_tvalid <= 1'b1;
            m_tuser <= 1'b1;
            m_tdata <= {cnt[s_tdata[119:118]], 8'd0};
          end
        end
        ST_SCAN: begin
          // Advance the read address one slot a cycle; compare that slot in the next cycle
          qv <= (sc < (SLOT_W+1)'(RULE_SLOTS));
          qslot <= sc[SLOT_W-1:0];
          if (sc < (SLOT_W+1)'(RULE_SLOTS)) sc <= sc + 1'b1;
          if (qv && (match || qslot == SLOT_W'(RULE_SLOTS - 1))) begin
            state <= ST_IDLE;
            qv <= 1'b0;
            m_tvalid <= 1'b1;
            m_tuser <= 1'b0;
            cnt[CNT_PROCESSED] <= cnt[CNT_PROCESSED] + 64'd1;
            if (match) begin
              m_tdata <= {64'd0, 4'(qslot), 1'b1, CLS_RULES, rq.drop};
              if (rq.drop) cnt[CNT_DROPPED] <= cnt[CNT_DROPPED] + 64'd1;
              else cnt[CNT_PASSED] <= cnt[CNT_PASSED] + 64'd1;
            end else begin
              m_tdata <= {64'd0, 4'd0, 1'b0, CLS_RULES, 1'b0};
              cnt[CNT_PASSED] <= cnt[CNT_PASSED] + 64'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !s_tready) else $error("input taken during scan");

  a_compare_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    qv |-> (state == ST_SCAN)) else $error("compare outside scan");

  a_no_hit_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser && !m_tdata[3]) |-> (m_tdata[7:4] == 4'd0))
    else $error("slot reported without hit");

endmodule

// ===== rtl/fpf_rule_ram.sv =====
module fpf_rule_ram
  import fpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  rule_t             wdata,
  input  logic              wen_bit,
  input  logic [SLOT_W-1:0] raddr,
  output rule_t             rdata,
  output logic              ren_bit
);

  rule_t mem [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] enabled;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Enable bits reset to zero so every slot starts disabled
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
      ren_bit <= 1'b0;
    end else begin
      if (we) begin
        enabled[waddr] <= wen_bit;
      end
      ren_bit <= enabled[raddr];
    end
  end

endmodule
